// File: rtl/mfbh_pkg.sv
`timescale 1ns / 1ps
// Shared constants, state types and a control struct for the multiply-fold byte hash.
// No dependencies; the top level, the lanes and the merge stage import this package.
package mfbh_pkg;

    localparam int unsigned LEN_BITS      = 32;
    localparam int unsigned KEY_SHORT_MAX = 16;

    localparam logic [63:0] HC0 = 64'h910a2dec89025cc1;
    localparam logic [63:0] HC1 = 64'hbeeb8da1658eec67;
    localparam logic [63:0] HC2 = 64'hf893a2eefb32555f;
    localparam logic [63:0] HC3 = 64'h71c18690ee42c90b;
    localparam logic [63:0] HC4 = 64'h71bb54d8d101b5b9;
    localparam logic [63:0] HC5 = 64'hc34d0bff90150281;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_DISPATCH,
        ST_LANE,
        ST_MERGE,
        ST_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        MG_IDLE,
        MG_FIRST,
        MG_SECOND
    } merge_state_t;

    typedef struct packed {
        logic load;
        logic start;
    } lane_ctrl_t;

endpackage

// File: rtl/multiply_fold_byte_hash.sv
`timescale 1ns / 1ps
// Multiply-fold byte hash top level: chunk intake, length mix, two lanes, merge, output word.
// A middle chunk of a long key runs one update in both lanes; a first chunk runs the length
// mix before that. A last chunk runs the merge and puts its hash in the output register once
// the output is free, and a new word is taken from then on. Every step is set by the 64x64
// multiplier (four 32x32 partial products) in each lane, in the merge stage and the length mix.
// Synchronous active-low reset clears control, lane accumulators and length state.
module multiply_fold_byte_hash (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_first_chunk,
    input  logic                          s_last_chunk,
    input  logic [63:0]                   s_chunk_low_word,
    input  logic [63:0]                   s_chunk_high_word,
    input  logic [31:0]                   s_key_length,
    input  logic [63:0]                   s_seed_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [63:0]                   m_hash_value
);
    import mfbh_pkg::*;

    top_state_t state_reg;
    top_state_t state_next;

    logic [LEN_BITS-1:0] held_in;
    logic [LEN_BITS-1:0] held_length_reg;
    logic                long_key_reg;
    logic [63:0]         length_mix_reg;
    logic [63:0]         length_mix_next;
    logic                last_reg;
    logic [63:0]         lo_reg;
    logic [63:0]         hi_reg;
    logic [63:0]         seed_reg;
    logic [63:0]         prev_lo_reg;
    logic [63:0]         prev_hi_reg;
    logic                m_valid_reg;
    logic [63:0]         m_hash_value_reg;

    logic        accept;
    logic        mix_start;
    logic        mix_done;
    logic [63:0] mix_lo;
    logic        mix_write;
    lane_ctrl_t  lane_ctrl;
    logic        prev_write;
    logic        merge_start;
    logic        merge_done;
    logic [63:0] merge_hash;
    logic        out_free;
    logic        out_load;
    logic [63:0] lane_zero_acc;
    logic [63:0] lane_one_acc;
    logic        lane_zero_done;
    logic        lane_one_done;

    assign held_in         = LEN_BITS'(64'(s_key_length));
    assign accept          = s_valid && s_ready;
    assign length_mix_next = seed_reg ^ mix_lo;
    assign out_free        = !m_valid_reg || m_ready;

    mfbh_mul u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .op_x    (HC0),
        .op_y    (64'(held_in) + 64'd1),
        .done    (mix_done),
        .prod_lo (mix_lo),
        .prod_hi ()
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        mix_start   = 1'b0;
        mix_write   = 1'b0;
        lane_ctrl   = '0;
        prev_write  = 1'b0;
        merge_start = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mix_start  = s_first_chunk;
                    state_next = s_first_chunk ? ST_MIX : ST_DISPATCH;
                end
            end
            ST_MIX: begin
                if (mix_done) begin
                    mix_write      = 1'b1;
                    lane_ctrl.load = 1'b1;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (last_reg) begin
                    merge_start = 1'b1;
                    state_next  = ST_MERGE;
                end else if (long_key_reg) begin
                    lane_ctrl.start = 1'b1;
                    prev_write      = 1'b1;
                    state_next      = ST_LANE;
                end else begin
                    // middle word of a short key: drop it
                    state_next = ST_IDLE;
                end
            end
            ST_LANE: begin
                if (lane_zero_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MERGE: begin
                if (merge_done) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_length_reg <= '0;
            long_key_reg    <= 1'b0;
            length_mix_reg  <= 64'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept && s_first_chunk) begin
                held_length_reg <= held_in;
                long_key_reg    <= held_in > LEN_BITS'(KEY_SHORT_MAX);
            end
            if (mix_write) begin
                length_mix_reg <= length_mix_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= s_last_chunk;
            lo_reg   <= s_chunk_low_word;
            hi_reg   <= s_chunk_high_word;
            if (s_first_chunk) begin
                seed_reg <= s_seed_value;
            end
        end
        if (prev_write) begin
            prev_lo_reg <= lo_reg;
            prev_hi_reg <= hi_reg;
        end
        if (out_load) begin
            m_hash_value_reg <= merge_hash;
        end
    end

    mfbh_lane u_lane_zero (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lane_ctrl),
        .load_value (length_mix_next ^ HC1),
        .data_word  (lo_reg),
        .lane_key   (HC3),
        .acc_value  (lane_zero_acc),
        .done       (lane_zero_done)
    );

    mfbh_lane u_lane_one (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lane_ctrl),
        .load_value (length_mix_next ^ HC2),
        .data_word  (hi_reg),
        .lane_key   (HC4),
        .acc_value  (lane_one_acc),
        .done       (lane_one_done)
    );

    mfbh_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (merge_start),
        .long_key      (long_key_reg),
        .held_length   (held_length_reg),
        .prev_lo       (prev_lo_reg),
        .prev_hi       (prev_hi_reg),
        .cur_lo        (lo_reg),
        .cur_hi        (hi_reg),
        .length_mix    (length_mix_reg),
        .lane_zero_acc (lane_zero_acc),
        .lane_one_acc  (lane_one_acc),
        .done          (merge_done),
        .hash_value    (merge_hash)
    );

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_value_reg;

    // both lanes start together and must finish together
    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_zero_done == lane_one_done)
        else $error("lane multipliers out of step");

    a_merge_done_in_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        merge_done |-> (state_reg == ST_MERGE))
        else $error("merge finished outside the merge state");

    a_first_goes_to_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_first_chunk) |=> (state_reg == ST_MIX))
        else $error("first word did not start the length mix");

endmodule

// File: rtl/mfbh_mul.sv
`timescale 1ns / 1ps
// Multi-cycle 64x64 -> 128 multiplier: one 32x32 partial product per cycle, accumulated.
// Standalone; used by the lanes, the merge stage and the length mix in the top level.
module mfbh_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_x,
    input  logic [63:0] op_y,
    output logic        done,
    output logic [63:0] prod_lo,
    output logic [63:0] prod_hi
);

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [63:0]  x_reg;
    logic [63:0]  y_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic [63:0]  pp_reg;
    logic [63:0]  pp_next;
    logic [1:0]   pp_sh_reg;
    logic [1:0]   pp_sh_next;
    logic         pp_vld_reg;
    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic [31:0]  part_x;
    logic [31:0]  part_y;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0: begin
                part_x     = x_reg[31:0];
                part_y     = y_reg[31:0];
                pp_sh_next = 2'd0;
            end
            2'd1: begin
                part_x     = x_reg[31:0];
                part_y     = y_reg[63:32];
                pp_sh_next = 2'd1;
            end
            2'd2: begin
                part_x     = x_reg[63:32];
                part_y     = y_reg[31:0];
                pp_sh_next = 2'd1;
            end
            default: begin
                part_x     = x_reg[63:32];
                part_y     = y_reg[63:32];
                pp_sh_next = 2'd2;
            end
        endcase
        pp_next  = part_x * part_y;
        acc_next = acc_reg + ({64'd0, pp_reg} << {pp_sh_reg, 5'd0});
    end

    // product is complete once the last partial product has been added
    assign done    = busy_reg && (cnt_reg == LAST_STEP) && !pp_vld_reg;
    assign prod_lo = acc_reg[63:0];
    assign prod_hi = acc_reg[127:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            pp_vld_reg <= 1'b0;
        end else if (start) begin
            busy_reg   <= 1'b1;
            cnt_reg    <= 3'd0;
            pp_vld_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg != LAST_STEP) begin
                cnt_reg    <= cnt_reg + 3'd1;
                pp_vld_reg <= 1'b1;
            end else begin
                pp_vld_reg <= 1'b0;
            end
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= op_x;
            y_reg   <= op_y;
            acc_reg <= 128'd0;
        end else if (busy_reg) begin
            if (cnt_reg != LAST_STEP) begin
                pp_reg    <= pp_next;
                pp_sh_reg <= pp_sh_next;
            end
            if (pp_vld_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

endmodule

// File: rtl/mfbh_lane.sv
`timescale 1ns / 1ps
// One hash lane: accumulator plus multiply-fold update with a per-lane key constant.
// Depends on mfbh_pkg and mfbh_mul.
module mfbh_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  mfbh_pkg::lane_ctrl_t ctrl,
    input  logic [63:0]        load_value,
    input  logic [63:0]        data_word,
    input  logic [63:0]        lane_key,
    output logic [63:0]        acc_value,
    output logic               done
);
    import mfbh_pkg::*;

    logic [63:0] acc_reg;
    logic [63:0] base;
    logic [63:0] mul_lo;
    logic [63:0] mul_hi;
    logic        mul_done;

    // a load in the same cycle as a start seeds the update with the new value
    assign base = ctrl.load ? load_value : acc_reg;

    mfbh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.start),
        .op_x    (base ^ data_word),
        .op_y    (lane_key),
        .done    (mul_done),
        .prod_lo (mul_lo),
        .prod_hi (mul_hi)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 64'd0;
        end else if (ctrl.load) begin
            acc_reg <= load_value;
        end else if (mul_done) begin
            acc_reg <= mul_lo ^ mul_hi;
        end
    end

    assign acc_value = acc_reg;
    assign done      = mul_done;

endmodule

// File: rtl/mfbh_merge.sv
`timescale 1ns / 1ps
// Merge stage: shapes the key tail, folds in both lanes for a long key and runs the two final multiplies.
// Depends on mfbh_pkg and mfbh_mul.
module mfbh_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          long_key,
    input  logic [mfbh_pkg::LEN_BITS-1:0] held_length,
    input  logic [63:0]                   prev_lo,
    input  logic [63:0]                   prev_hi,
    input  logic [63:0]                   cur_lo,
    input  logic [63:0]                   cur_hi,
    input  logic [63:0]                   length_mix,
    input  logic [63:0]                   lane_zero_acc,
    input  logic [63:0]                   lane_one_acc,
    output logic                          done,
    output logic [63:0]                   hash_value
);
    import mfbh_pkg::*;

    merge_state_t state_reg;
    merge_state_t state_next;

    logic [255:0] window;
    logic [255:0] win_a;
    logic [255:0] win_c;
    logic [4:0]   n5;
    logic [4:0]   left;
    logic [4:0]   pos_a;
    logic [4:0]   pos_c;
    logic [1:0]   end_sh;
    logic [7:0]   mid_byte;
    logic [7:0]   end_byte;
    logic [63:0]  tail_a;
    logic [63:0]  tail_c;
    logic         mul_start;
    logic [63:0]  mul_x;
    logic [63:0]  mul_y;
    logic         mul_done;
    logic [63:0]  mul_lo;
    logic [63:0]  mul_hi;

    // bytes 0..15 are the kept chunk, 16..31 the last chunk
    assign window = {cur_hi, cur_lo, prev_hi, prev_lo};

    always_comb begin
        n5     = held_length[4:0];
        left   = {1'b0, held_length[3:0] - 4'd1} + 5'd1;
        pos_a  = 5'd16;
        pos_c  = 5'd16;
        if (long_key) begin
            pos_a = left;
            pos_c = left + 5'd8;
        end else if (n5 >= 5'd8) begin
            pos_c = n5 + 5'd8;
        end else begin
            pos_c = n5 + 5'd12;
        end
        win_a    = window >> {pos_a, 3'b000};
        win_c    = window >> {pos_c, 3'b000};
        end_sh   = n5[1:0] - 2'd1;
        mid_byte = n5[1] ? cur_lo[15:8] : cur_lo[7:0];
        end_byte = 8'(cur_lo >> {end_sh, 3'b000});

        if (long_key) begin
            tail_a = lane_zero_acc ^ win_a[63:0];
            tail_c = lane_one_acc ^ win_c[63:0];
        end else if (n5 >= 5'd8) begin
            tail_a = win_a[63:0];
            tail_c = win_c[63:0];
        end else if (n5 >= 5'd4) begin
            tail_a = {32'd0, win_a[31:0]};
            tail_c = {32'd0, win_c[31:0]};
        end else if (n5 != 5'd0) begin
            tail_a = {40'd0, cur_lo[7:0], mid_byte, end_byte};
            tail_c = 64'd0;
        end else begin
            tail_a = 64'd0;
            tail_c = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_x      = (tail_a ^ length_mix);
        mul_y      = (tail_c ^ HC5);
        done       = 1'b0;
        case (state_reg)
            MG_IDLE: begin
                if (start) begin
                    mul_start  = 1'b1;
                    state_next = MG_FIRST;
                end
            end
            MG_FIRST: begin
                mul_x = mul_lo ^ HC1;
                mul_y = mul_hi ^ HC2;
                if (mul_done) begin
                    mul_start  = 1'b1;
                    state_next = MG_SECOND;
                end
            end
            MG_SECOND: begin
                if (mul_done) begin
                    done       = 1'b1;
                    state_next = MG_IDLE;
                end
            end
            default: begin
                state_next = MG_IDLE;
            end
        endcase
    end

    mfbh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_x    (mul_x),
        .op_y    (mul_y),
        .done    (mul_done),
        .prod_lo (mul_lo),
        .prod_hi (mul_hi)
    );

    // product holds until the next start, so the hash stays valid after done
    assign hash_value = mul_lo ^ mul_hi;

endmodule
